// ===== src/sorted_set_store_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted set store
// Shared property forms for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_SET_STORE_ASSERT_SVH
`define SORTED_SET_STORE_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define SSST_ASSERT_HOLDS(label, ck, rn, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define SSST_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/ssst_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted set store package
// Sizes, operation and status codes, and the controller/datapath link types.
// ---------------------------------------------------------------------------
package ssst_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_LIST_ASC  = 3'd2;
    localparam logic [OP_W-1:0] OP_LIST_DESC = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [ST_W-1:0] ST_LISTED    = 3'd6;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd7;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC,
        IDX_DEC,
        IDX_CNT,
        IDX_POS
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1,
        RD_LIST
    } rd_sel_t;

    typedef struct packed {
        logic            load;
        idx_op_t         idx_op;
        logic            pos_load;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            wr_en;
        logic            wr_new;
        cnt_op_t         cnt_op;
        logic            emit;
        logic [ST_W-1:0] emit_status;
        logic            emit_entry;
        logic            emit_last;
    } ssst_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_eq_cnt;
        logic            idx_eq_pos;
        logic            idx_last;
        logic            cnt_zero;
        logic            cnt_full;
        logic            key_lt;
        logic            key_eq;
        logic            out_free;
    } ssst_stat_t;

endpackage

// ===== src/ssst_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ssst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ssst_dp.sv =====
// ---------------------------------------------------------------------------
// Sorted set store datapath
// Request registers, index and count, entry RAM and the result register.
// ---------------------------------------------------------------------------
`include "sorted_set_store_assert.svh"

module ssst_dp
    import ssst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ssst_cmd_t                cmd,
    output ssst_stat_t               stat,
    input  logic [OP_W-1:0]          in_op,
    input  logic signed [DATA_W-1:0] in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ST_W-1:0]          out_status,
    output logic signed [DATA_W-1:0] out_entry,
    output logic                     out_last
);

    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ST_W-1:0]          out_status_reg;
    logic signed [DATA_W-1:0] out_entry_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]  idx_m1, idx_p1, idx_rev, rd_full, wr_full;
    logic [DATA_W-1:0] rd_data, wr_data;

    assign idx_m1  = idx_reg - CNT_W'(1);
    assign idx_p1  = idx_reg + CNT_W'(1);
    assign idx_rev = cnt_reg - idx_p1;

    // Read address: scan index, its neighbors, or the listing order.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    rd_full = idx_reg;
            RD_IDX_M1: rd_full = idx_m1;
            RD_IDX_P1: rd_full = idx_p1;
            RD_LIST:   rd_full = (op_reg == OP_LIST_DESC) ? idx_rev : idx_reg;
            default:   rd_full = idx_reg;
        endcase
    end

    assign wr_full = cmd.wr_new ? pos_reg : idx_reg;
    assign wr_data = cmd.wr_new ? value_reg : rd_data;

    ssst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_full[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_CLR:  idx_next = '0;
            IDX_INC:  idx_next = idx_p1;
            IDX_DEC:  idx_next = idx_m1;
            IDX_CNT:  idx_next = cnt_reg;
            IDX_POS:  idx_next = pos_reg;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
            CNT_CLR:  cnt_next = '0;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.pos_load)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_entry_reg  <= cmd.emit_entry ? $signed(rd_data) : '0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign stat.op         = op_reg;
    assign stat.idx_eq_cnt = (idx_reg == cnt_reg);
    assign stat.idx_eq_pos = (idx_reg == pos_reg);
    assign stat.idx_last   = ({1'b0, idx_reg} + (CNT_W + 1)'(1)) >= {1'b0, cnt_reg};
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_full   = (cnt_reg == CNT_W'(CAPACITY));
    assign stat.key_lt     = ($signed(rd_data) < value_reg);
    assign stat.key_eq     = (rd_data == $unsigned(value_reg));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_entry  = out_entry_reg;
    assign out_last   = out_last_reg;

    `SSST_ASSERT_HOLDS(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SSST_ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, !out_valid_reg || out_ready, "result overwritten")
    `SSST_ASSERT_IMPLIES(a_wr_range, clk, rst_n, cmd.wr_en, wr_full < CNT_W'(CAPACITY), "write past store")
    `SSST_ASSERT_IMPLIES(a_inc_room, clk, rst_n, cmd.cnt_op == CNT_INC, cnt_reg != CNT_W'(CAPACITY), "insert into full store")

endmodule

// ===== src/ssst_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sorted set store controller
// Sequences search, shift, listing and reply steps for one request at a time.
// ---------------------------------------------------------------------------
module ssst_ctrl
    import ssst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ssst_stat_t stat,
    output ssst_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DECIDE,
        S_INS_SHIFT,
        S_INS_WR,
        S_REM_SHIFT,
        S_REM_WR,
        S_REPLY,
        S_LIST_RD,
        S_LIST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] reply_reg, reply_next;
    logic            match_reg, match_next;

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        match_next = match_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_INSERT:
                    begin
                        cmd.idx_op = IDX_CLR;
                        state_next = S_SRCH_RD;
                    end
                    OP_REMOVE, OP_LIST_ASC, OP_LIST_DESC:
                    begin
                        cmd.idx_op = IDX_CLR;
                        if (stat.cnt_zero)
                        begin
                            reply_next = ST_EMPTY;
                            state_next = S_REPLY;
                        end
                        else if (stat.op == OP_REMOVE)
                        begin
                            state_next = S_SRCH_RD;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                        reply_next = ST_CLEARED;
                        state_next = S_REPLY;
                    end
                    default:
                    begin
                        // unused codes: drop without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRCH_RD:
            begin
                if (stat.idx_eq_cnt)
                begin
                    cmd.pos_load = 1'b1;
                    match_next   = 1'b0;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (stat.key_lt)
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    cmd.pos_load = 1'b1;
                    match_next   = stat.key_eq;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.op == OP_INSERT)
                begin
                    if (match_reg)
                    begin
                        reply_next = ST_DUPLICATE;
                        state_next = S_REPLY;
                    end
                    else if (stat.cnt_full)
                    begin
                        reply_next = ST_FULL;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_CNT;
                        state_next = S_INS_SHIFT;
                    end
                end
                else if (!match_reg)
                begin
                    reply_next = ST_NOTFOUND;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.idx_op = IDX_POS;
                    state_next = S_REM_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                if (stat.idx_eq_pos)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_new = 1'b1;
                    cmd.cnt_op = CNT_INC;
                    reply_next = ST_INSERTED;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_INS_SHIFT;
            end
            S_REM_SHIFT:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    reply_next = ST_REMOVED;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_REM_SHIFT;
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = reply_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LIST;
                state_next = S_LIST_EMIT;
            end
            S_LIST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_LISTED;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_last   = stat.idx_last;
                    if (stat.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= ST_INSERTED;
            match_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            match_reg <= match_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== src/sorted_set_store.sv =====
// ---------------------------------------------------------------------------
// Sorted set store
// Ordered set of up to CAPACITY distinct signed 32-bit values with insert,
// remove, ascending and descending listing, and clear.
// ---------------------------------------------------------------------------
//
//  Channel   | Dir | tdata             | tuser          | tlast
//  ----------+-----+-------------------+----------------+----------------
//  s_axis    | in  | value [31:0]      | operation[2:0] | -
//  m_axis    | out | entry_value[31:0] | status [2:0]   | last of the run
//
//  One request is handled at a time; entries live in a single-port-pair RAM,
//  so every shift step is one read followed by one write. Insert and remove
//  first run an ordered search one entry at a time, then the shift loop over
//  the tail; listing reads and emits one entry at a time.
//  Reset clears the count, the result valid flag and the controller state;
//  RAM contents are never read above the count, so no clearing pass is
//  needed. A stalled m_axis holds the result register; the next request is
//  taken as soon as the previous one has placed its final result there.
//
module sorted_set_store
    import ssst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_axis_tuser,   // [2:0] operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] entry_value
    output logic [ST_W-1:0]   m_axis_tuser,   // [2:0] status
    output logic              m_axis_tlast
);

    ssst_cmd_t                cmd;
    ssst_stat_t               stat;
    logic signed [DATA_W-1:0] entry;

    // Sequence each request: search, shift, list, reply.
    ssst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the request, the entries and the pending result.
    ssst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_axis_tuser),
        .in_value   ($signed(s_axis_tdata)),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_entry  (entry),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = $unsigned(entry);

endmodule

// ===== verif/sorted_set_store_tb.sv =====
// ---------------------------------------------------------------------------
// Sorted set store testbench
// Drives insert, remove, list and clear requests with random gaps on both
// streams and checks every result against an in-bench model of the set.
// ---------------------------------------------------------------------------
module sorted_set_store_tb;
    import ssst_pkg::*;

    // Longest stretch with no handshake on either stream before giving up.
    // The longest legal stall is the deliberate receiver hold-off, HOLD_OFF.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_OFF       = 300;
    localparam int MAX_REPORTS    = 10;

    // Codes above clear are not operations; the block must ignore them.
    localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

    localparam logic [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] entry_value;
        logic              last;
    } reply_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = OP_INSERT;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]   m_axis_tuser;
    logic              m_axis_tlast;

    // Requests waiting for the driver, results still owed by the block, and
    // the set contents as the block should hold them, kept sorted ascending.
    request_t                 request_q[$];
    reply_t                   reply_q[$];
    logic signed [DATA_W-1:0] shadow_set[$];

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int recv_hold_cycles = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;

    sorted_set_store dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Set model
    // -----------------------------------------------------------------------

    function automatic void owe_reply(logic [ST_W-1:0] status, logic [DATA_W-1:0] val,
                                      logic last);
        reply_t r;
        r.status      = status;
        r.entry_value = val;
        r.last        = last;
        reply_q.push_back(r);
    endfunction

    // Update the shadow set for one accepted request and queue the results it owes.
    function automatic void apply_request(request_t req);
        logic signed [DATA_W-1:0] v;
        int                       pos;
        int                       n;
        v   = req.value;
        n   = shadow_set.size();
        pos = 0;
        // Ordered search: first slot not below the value (signed compare).
        while (pos < n && shadow_set[pos] < v)
            pos++;
        case (req.op)
            OP_INSERT:
            begin
                // Duplicate wins over full.
                if (pos < n && shadow_set[pos] == v)
                    owe_reply(ST_DUPLICATE, '0, 1'b1);
                else if (n >= CAPACITY)
                    owe_reply(ST_FULL, '0, 1'b1);
                else
                begin
                    shadow_set.insert(pos, v);
                    owe_reply(ST_INSERTED, '0, 1'b1);
                end
            end
            OP_REMOVE:
            begin
                if (n == 0)
                    owe_reply(ST_EMPTY, '0, 1'b1);
                else if (pos < n && shadow_set[pos] == v)
                begin
                    shadow_set.delete(pos);
                    owe_reply(ST_REMOVED, '0, 1'b1);
                end
                else
                    owe_reply(ST_NOTFOUND, '0, 1'b1);
            end
            OP_LIST_ASC, OP_LIST_DESC:
            begin
                if (n == 0)
                    owe_reply(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        owe_reply(ST_LISTED,
                                  shadow_set[(req.op == OP_LIST_ASC) ? i : n - 1 - i],
                                  i == n - 1);
            end
            OP_CLEAR:
            begin
                shadow_set.delete();
                owe_reply(ST_CLEARED, '0, 1'b1);
            end
            default:
                ;   // unused code: no result, set unchanged
        endcase
    endfunction

    // Mostly short gaps, now and then a long one; none at all with pct 0.
    function automatic int pick_gap(int idle_pct);
        if (int'($urandom_range(99)) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 15);
        return $urandom_range(3, 1);
    endfunction

    // -----------------------------------------------------------------------
    // Request side: pull from request_q, hold each request until accepted,
    // then insert the chosen gap before the next one. Only one assignment to
    // tvalid per edge, so back-to-back requests keep it high.
    // -----------------------------------------------------------------------
    initial
    begin : request_driver
        request_t req;
        int       gap;
        gap = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready)
            begin
                req.op    = s_axis_tuser;
                req.value = s_axis_tdata;
                apply_request(req);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req.value;
                    s_axis_tuser  <= req.op;
                    gap = pick_gap(send_idle_pct);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off when a test asks for
    // one through recv_hold_cycles. The hold is counted down here.
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (recv_hold_cycles > 0)
            begin
                stall            = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap(recv_idle_pct);
            end
        end
    end

    // Compare each accepted result with the oldest one owed.
    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reply_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d value %0d last %0d",
                             m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
            end
            else
            begin
                want = reply_q.pop_front();
                if (want.status !== m_axis_tuser || want.entry_value !== m_axis_tdata ||
                    want.last !== m_axis_tlast)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected status %0d value %0d last %0d,",
                                  " got status %0d value %0d last %0d"},
                                 want.status, $signed(want.entry_value), want.last,
                                 m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
                end
            end
        end
    end

    // Abort when neither stream moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_set_store test failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Test tasks
    // -----------------------------------------------------------------------

    task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        request_t req;
        req.op    = op;
        req.value = val;
        request_q.push_back(req);
    endtask

    // Hold until every request is accepted and every owed result has arrived.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (request_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0);
    endtask

    // Empty-store answers and the ignored operation codes.
    task automatic test_empty_store();
        send_request(OP_LIST_ASC, $urandom);
        send_request(OP_LIST_DESC, $urandom);
        send_request(OP_REMOVE, $urandom);
        send_request(OP_CLEAR, $urandom);
        send_request(OP_CLEAR, $urandom);   // clear of an already empty store
        for (int c = int'(OP_CLEAR) + 1; c <= int'(OP_TOP_CODE); c++)
            send_request(OP_W'(c), $urandom);
        send_request(OP_LIST_ASC, '0);
        wait_drained();
    endtask

    // Signed extremes, ordering around zero, duplicate, absent value.
    task automatic test_value_extremes();
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_INSERT, VALUE_MIN);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, DATA_W'(1));
        send_request(OP_INSERT, VALUE_MIN);
        send_request(OP_LIST_ASC, '0);
        send_request(OP_LIST_DESC, '1);
        send_request(OP_REMOVE, DATA_W'(5));
        send_request(OP_REMOVE, VALUE_MAX);
        send_request(OP_REMOVE, VALUE_MIN);
        send_request(OP_REMOVE, VALUE_MIN);
        send_request(OP_LIST_ASC, '0);
        send_request(OP_CLEAR, '0);
        send_request(OP_LIST_DESC, '0);
        wait_drained();
    endtask

    // Fill the store while the receiver holds off, so the block backs up and
    // stalls its input; then full insert, duplicate into full, full listings.
    task automatic test_backpressure();
        logic [DATA_W-1:0] first_val;
        send_idle_pct    = 0;
        recv_hold_cycles = HOLD_OFF;
        first_val        = $urandom;
        send_request(OP_CLEAR, '0);
        send_request(OP_INSERT, first_val);
        for (int i = 1; i < CAPACITY; i++)
            send_request(OP_INSERT, $urandom);
        send_request(OP_INSERT, $urandom);
        send_request(OP_INSERT, first_val);
        send_request(OP_LIST_ASC, '0);
        send_request(OP_LIST_DESC, '0);
        send_request(OP_REMOVE, first_val);
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_LIST_ASC, '0);
        wait_drained();
    endtask

    // Random traffic drawn mostly from a small pool of values, so removes
    // find their target and duplicates occur.
    task automatic test_random_traffic(int items, int pool_size, int s_idle, int r_idle);
        logic [DATA_W-1:0] pool[];
        int                pick;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        pool = new[pool_size];
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = VALUE_MIN;
        pool[1] = VALUE_MAX;
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(OP_INSERT, pool[$urandom_range(pool_size - 1)]);
            else if (pick < 68)
                send_request(OP_REMOVE, pool[$urandom_range(pool_size - 1)]);
            else if (pick < 78)
                send_request(OP_LIST_ASC, $urandom);
            else if (pick < 88)
                send_request(OP_LIST_DESC, $urandom);
            else if (pick < 92)
                send_request(OP_CLEAR, $urandom);
            else if (pick < 97)
                send_request($urandom_range(1) ? OP_INSERT : OP_REMOVE, $urandom);
            else
                send_request(OP_W'($urandom_range(int'(OP_TOP_CODE), int'(OP_CLEAR) + 1)),
                             $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_value_extremes();
        test_backpressure();
        test_random_traffic(24, 6, 0, 0);      // back to back, duplicate-heavy
        test_random_traffic(24, 24, 30, 30);   // moderate stalls on both sides
        test_random_traffic(24, 48, 20, 60);   // receiver-limited

        // Let any late result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("sorted_set_store test passed");
        else
            $display("sorted_set_store test failed");
        $finish;
    end

endmodule
